>>> design/dpet_pkg.sv
// Shared types and constants for the debounced pin edge event table.
package dpet_pkg;

  localparam int TABLE_ENTRIES_DEF = 16;
  localparam int MAX_RESULTS       = 16;
  localparam int CNT_W             = $clog2(MAX_RESULTS + 1);
  localparam int LINES             = 16;
  localparam logic [15:0] WINDOW_RESET = 16'd70;

  typedef enum logic [1:0] {
    OP_REG   = 2'd0,
    OP_UNREG = 2'd1,
    OP_EDGE  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    K_NONE  = 2'd0,
    K_REG   = 2'd1,
    K_UNREG = 2'd2,
    K_EDGE  = 2'd3
  } kind_t;

  localparam logic [1:0] TRIG_RISE = 2'd1;
  localparam logic [1:0] TRIG_FALL = 2'd2;

  localparam logic [1:0] ADDR_WINDOW = 2'd0;

  typedef struct packed {
    logic             valid;
    kind_t            kind;
    logic [4:0]       pin;
    logic [31:0]      tm;
    logic             taken;
    logic [CNT_W-1:0] count;
  } tok_t;

  typedef struct packed {
    logic       valid;
    logic [4:0] pin;
  } rep_t;

endpackage

>>> design/dpet_cell.sv
// One table slot: holds its pin and last report time and passes the request token on.
module dpet_cell import dpet_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic [15:0] window,
  input  tok_t        tok_in,
  output tok_t        tok_out,
  output rep_t        rep
);

  logic        active;
  logic [4:0]  pin;
  logic [31:0] last_time;

  logic        active_next;
  logic [4:0]  pin_next;
  logic [31:0] last_time_next;
  tok_t        tok_next;
  rep_t        rep_next;
  logic [31:0] diff;

  always_comb begin
    active_next    = active;
    pin_next       = pin;
    last_time_next = last_time;
    tok_next       = tok_in;
    rep_next       = '0;
    diff           = tok_in.tm - last_time;
    if (tok_in.valid) begin
      case (tok_in.kind)
        K_REG: begin
          if (!tok_in.taken && !active) begin
            active_next    = 1'b1;
            pin_next       = tok_in.pin;
            tok_next.taken = 1'b1;
          end
        end
        K_UNREG: begin
          if (!tok_in.taken && active && (pin == tok_in.pin)) begin
            active_next    = 1'b0;
            tok_next.taken = 1'b1;
          end
        end
        K_EDGE: begin
          if (active && (pin[3:0] == tok_in.pin[3:0]) &&
              (tok_in.count < CNT_W'(MAX_RESULTS)) && (diff >= {16'd0, window})) begin
            last_time_next = tok_in.tm;
            rep_next.valid = 1'b1;
            rep_next.pin   = pin;
            tok_next.count = tok_in.count + CNT_W'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      last_time <= '0;
      tok_out   <= '0;
      rep       <= '0;
    end else begin
      active    <= active_next;
      last_time <= last_time_next;
      tok_out   <= tok_next;
      rep       <= rep_next;
    end
  end

  always_ff @(posedge clk) begin
    pin <= pin_next;
  end

endmodule

>>> design/debounced_pin_edge_event_table_top.sv
// Top level: line settings, request issue, slot chain and result sequencing.
//
//   channel   signals                                          handshake
//   request   op pin_number trigger edge_rising time_now       start / busy
//   result    ok report_valid reported_pin last                strobe, one cycle
//   config    psel penable pwrite paddr pwdata prdata pready   APB, pready tied high
//
// An accepted request is registered as the issue token, walks the slot chain one cell
// per cycle and then passes the fin register, so the chain length sets its duration.
// Reports leave in slot order, one per cycle at most, the last one flagged.
// Reset is synchronous: it clears all slots, line settings and sets the window to 70.
// Results cannot be stalled; busy stays high until the final result is out.
module debounced_pin_edge_event_table_top import dpet_pkg::*; #(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  op,
  input  logic [5:0]  pin_number,
  input  logic [1:0]  trigger,
  input  logic        edge_rising,
  input  logic [31:0] time_now,
  output logic        strobe,
  output logic        ok,
  output logic        report_valid,
  output logic [4:0]  reported_pin,
  output logic        last,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [LINES-1:0] line_enable;
  logic [LINES-1:0] rise_enable;
  logic [LINES-1:0] fall_enable;
  logic [LINES-1:0] port_select;
  logic [15:0]      debounce_window;

  tok_t             issue;
  logic             ok_req;
  logic             pend_v;
  logic [4:0]       pend_pin;
  logic             fin;

  tok_t             chain [TABLE_ENTRIES+1];
  rep_t             reps  [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] rep_vec;
  logic             rep_any;
  logic [4:0]       rep_pin;

  logic             accept;
  logic             in_range;
  logic [LINES-1:0] bitm;
  logic [3:0]       line;
  logic             fire;
  logic             cfg_wr;
  tok_t             tok_new;
  logic             ok_new;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr == ADDR_WINDOW);
  assign prdata = (paddr == ADDR_WINDOW) ? {16'd0, debounce_window} : 32'd0;

  assign accept   = start && !busy;
  assign in_range = !pin_number[5];
  assign line     = pin_number[3:0];
  assign bitm     = LINES'(1) << line;
  assign fire     = in_range && line_enable[line] && (port_select[line] == pin_number[4]) &&
                    (edge_rising ? rise_enable[line] : fall_enable[line]);

  always_comb begin
    tok_new       = '0;
    tok_new.valid = 1'b1;
    tok_new.pin   = pin_number[4:0];
    tok_new.tm    = time_now;
    tok_new.kind  = K_NONE;
    ok_new        = 1'b0;
    case (op_t'(op))
      OP_REG: begin
        ok_new = in_range;
        if (in_range) tok_new.kind = K_REG;
      end
      OP_UNREG: begin
        ok_new = in_range;
        if (in_range) tok_new.kind = K_UNREG;
      end
      OP_EDGE: begin
        ok_new = 1'b1;
        if (fire) tok_new.kind = K_EDGE;
      end
      default: begin
        ok_new = 1'b0;
      end
    endcase
  end

  assign chain[0] = issue;

  for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
    dpet_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .window  (debounce_window),
      .tok_in  (chain[g]),
      .tok_out (chain[g+1]),
      .rep     (reps[g])
    );
    assign rep_vec[g] = reps[g].valid;
  end

  always_comb begin
    rep_pin = '0;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      rep_pin = rep_pin | (reps[i].valid ? reps[i].pin : 5'd0);
    end
  end
  assign rep_any = |rep_vec;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy            <= 1'b0;
      issue           <= '0;
      pend_v          <= 1'b0;
      fin             <= 1'b0;
      strobe          <= 1'b0;
      line_enable     <= '0;
      rise_enable     <= '0;
      fall_enable     <= '0;
      port_select     <= '0;
      debounce_window <= WINDOW_RESET;
    end else begin
      strobe      <= 1'b0;
      issue.valid <= 1'b0;
      fin         <= chain[TABLE_ENTRIES].valid;
      if (cfg_wr) begin
        debounce_window <= pwdata[15:0];
      end
      if (accept) begin
        busy   <= 1'b1;
        ok_req <= ok_new;
        issue  <= tok_new;
        if (op_t'(op) == OP_REG && in_range) begin
          line_enable <= line_enable | bitm;
          if (pin_number[4]) port_select <= port_select | bitm;
          else port_select <= port_select & ~bitm;
          if (trigger == TRIG_RISE) begin
            rise_enable <= rise_enable | bitm;
            fall_enable <= fall_enable & ~bitm;
          end else if (trigger == TRIG_FALL) begin
            rise_enable <= rise_enable & ~bitm;
            fall_enable <= fall_enable | bitm;
          end else begin
            rise_enable <= rise_enable | bitm;
            fall_enable <= fall_enable | bitm;
          end
        end
        if (op_t'(op) == OP_UNREG && in_range) begin
          line_enable <= line_enable & ~bitm;
          rise_enable <= rise_enable & ~bitm;
          fall_enable <= fall_enable & ~bitm;
        end
      end
      if (rep_any) begin
        if (pend_v) begin
          strobe       <= 1'b1;
          ok           <= 1'b1;
          report_valid <= 1'b1;
          reported_pin <= pend_pin;
          last         <= 1'b0;
        end
        pend_v   <= 1'b1;
        pend_pin <= rep_pin;
      end
      if (fin) begin
        strobe       <= 1'b1;
        ok           <= pend_v ? 1'b1 : ok_req;
        report_valid <= pend_v;
        reported_pin <= pend_v ? pend_pin : 5'd0;
        last         <= 1'b1;
        pend_v       <= 1'b0;
        busy         <= 1'b0;
      end
    end
  end

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy) else $error("busy not raised after request");
  a_one_report: assert property (@(posedge clk) disable iff (rst)
    $onehot0(rep_vec)) else $error("several slots reported in one cycle");
  a_report_ok: assert property (@(posedge clk) disable iff (rst)
    (strobe && report_valid) |-> ok) else $error("report without ok");
  a_pin_zero: assert property (@(posedge clk) disable iff (rst)
    (strobe && !report_valid) |-> (reported_pin == 5'd0)) else $error("stray pin");
  a_not_last_busy: assert property (@(posedge clk) disable iff (rst)
    (strobe && !last) |-> busy) else $error("request ended before last result");

endmodule

>>> dv/dpet_checker.sv
`timescale 1ns / 100ps
// Checker for the pin edge event table: tracks requests and register writes, scores each result.
module dpet_checker import dpet_pkg::*; #(
  parameter int ENTRIES = TABLE_ENTRIES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  logic [1:0]  op,
  input  logic [5:0]  pin_number,
  input  logic [1:0]  trigger,
  input  logic        edge_rising,
  input  logic [31:0] time_now,
  input  logic        strobe,
  input  logic        ok,
  input  logic        report_valid,
  input  logic [4:0]  reported_pin,
  input  logic        last,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic [31:0] prdata,
  input  logic        pready,
  output int          fail_count,
  output int          pending,
  output int          requests_seen,
  output int          reports_seen
);

  typedef struct packed {
    logic       ok;
    logic       hit;
    logic [4:0] pin;
    logic       fin;
  } outcome_t;

  outcome_t    due_q[$];
  logic        slot_used  [ENTRIES];
  logic [4:0]  slot_pin   [ENTRIES];
  logic [31:0] slot_stamp [ENTRIES];
  logic [15:0] line_on;
  logic [15:0] rise_on;
  logic [15:0] fall_on;
  logic [15:0] port_b_sel;
  logic [15:0] window;
  int          errors = 0;
  int          request_total = 0;
  int          report_total = 0;

  task automatic add_outcome(input logic okv, input logic hitv, input logic [4:0] p,
                             input logic fin);
    outcome_t o;
    o.ok  = okv;
    o.hit = hitv;
    o.pin = p;
    o.fin = fin;
    due_q.push_back(o);
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  task automatic apply_request(input logic [1:0] code, input logic [5:0] pin,
                               input logic [1:0] trig, input logic rise,
                               input logic [31:0] now);
    logic [3:0]  ln;
    logic [15:0] sel;
    logic        fired;
    logic        done;
    logic [4:0]  hit_pins [MAX_RESULTS];
    int          hits;
    int          idx;
    ln   = pin[3:0];
    sel  = 16'b1 << ln;
    hits = 0;
    done = 1'b0;
    case (op_t'(code))
      OP_REG: begin
        if (pin < 6'd32) begin
          if (pin[4]) port_b_sel = port_b_sel | sel;
          else port_b_sel = port_b_sel & ~sel;
          line_on = line_on | sel;
          if (trig == TRIG_RISE) begin
            rise_on = rise_on | sel;
            fall_on = fall_on & ~sel;
          end else if (trig == TRIG_FALL) begin
            rise_on = rise_on & ~sel;
            fall_on = fall_on | sel;
          end else begin
            rise_on = rise_on | sel;
            fall_on = fall_on | sel;
          end
          for (idx = 0; idx < ENTRIES; idx++) begin
            if (!done && !slot_used[idx]) begin
              slot_pin[idx]  = pin[4:0];
              slot_used[idx] = 1'b1;
              done = 1'b1;
            end
          end
        end
        add_outcome(pin < 6'd32, 1'b0, 5'd0, 1'b1);
      end
      OP_UNREG: begin
        if (pin < 6'd32) begin
          line_on = line_on & ~sel;
          rise_on = rise_on & ~sel;
          fall_on = fall_on & ~sel;
          for (idx = 0; idx < ENTRIES; idx++) begin
            if (!done && slot_used[idx] && slot_pin[idx] == pin[4:0]) begin
              slot_used[idx] = 1'b0;
              done = 1'b1;
            end
          end
        end
        add_outcome(pin < 6'd32, 1'b0, 5'd0, 1'b1);
      end
      OP_EDGE: begin
        fired = (pin < 6'd32) && line_on[ln] && (port_b_sel[ln] == pin[4]) &&
                (rise ? rise_on[ln] : fall_on[ln]);
        if (fired) begin
          for (idx = 0; idx < ENTRIES; idx++) begin
            if (hits < MAX_RESULTS && slot_used[idx] && slot_pin[idx][3:0] == ln &&
                (now - slot_stamp[idx]) >= {16'b0, window}) begin
              slot_stamp[idx] = now;
              hit_pins[hits]  = slot_pin[idx];
              hits++;
            end
          end
        end
        if (hits == 0) add_outcome(1'b1, 1'b0, 5'd0, 1'b1);
        for (idx = 0; idx < hits; idx++) add_outcome(1'b1, 1'b1, hit_pins[idx], idx == hits - 1);
      end
      default: add_outcome(1'b0, 1'b0, 5'd0, 1'b1);
    endcase
  endtask

  always @(posedge clk) begin
    outcome_t want;
    int       idx;
    if (rst) begin
      due_q.delete();
      for (idx = 0; idx < ENTRIES; idx++) begin
        slot_used[idx]  = 1'b0;
        slot_pin[idx]   = 5'd0;
        slot_stamp[idx] = 32'd0;
      end
      line_on    = 16'd0;
      rise_on    = 16'd0;
      fall_on    = 16'd0;
      port_b_sel = 16'd0;
      window     = WINDOW_RESET;
    end else begin
      if (strobe) begin
        if (report_valid) report_total++;
        if (due_q.size() == 0) begin
          $error("result with no request outstanding");
          errors++;
        end else begin
          want = due_q.pop_front();
          check_field("ok", 32'(want.ok), 32'(ok));
          check_field("report_valid", 32'(want.hit), 32'(report_valid));
          check_field("reported_pin", 32'(want.pin), 32'(reported_pin));
          check_field("last", 32'(want.fin), 32'(last));
        end
      end
      if (start && !busy) begin
        apply_request(op, pin_number, trigger, edge_rising, time_now);
        request_total++;
      end
      if (psel && penable && pready && paddr == ADDR_WINDOW) begin
        if (pwrite) window = pwdata[15:0];
        else check_field("prdata", {16'b0, window}, prdata);
      end
    end
    pending       <= due_q.size();
    fail_count    <= errors;
    requests_seen <= request_total;
    reports_seen  <= report_total;
  end

endmodule

>>> dv/tb.sv
`timescale 1ns / 100ps
// Testbench top for the pin edge event table: clock, reset, request and register stimulus.
module tb;
  import dpet_pkg::*;

  localparam int LATENCY     = TABLE_ENTRIES_DEF + 3;
  localparam int CYCLE_LIMIT = 300000;
  localparam int PHASES      = 5;
  localparam int PHASE_ITEMS = 84;

  logic        clk = 1'b0;
  logic        rst;
  logic        start;
  logic        busy;
  logic [1:0]  op;
  logic [5:0]  pin_number;
  logic [1:0]  trigger;
  logic        edge_rising;
  logic [31:0] time_now;
  logic        strobe;
  logic        ok;
  logic        report_valid;
  logic [4:0]  reported_pin;
  logic        last;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [1:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  int          fail_count;
  int          pending;
  int          requests_seen;
  int          reports_seen;
  int          cycles = 0;
  int          window_now;
  logic [31:0] clock_ms;
  logic [3:0]  line_pool [4];
  bit          steady;

  debounced_pin_edge_event_table_top u_dut (.*);

  dpet_checker u_check (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("debounced_pin_edge_event_table_top verification failed");
      $finish;
    end
  end

  task automatic idle_gap();
    int gap;
    gap = 0;
    if (!steady && $urandom_range(99) < 35) gap = $urandom_range(1, 30);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic issue(input op_t code, input logic [5:0] pin, input logic [1:0] trig,
                       input logic rise, input logic [31:0] now);
    idle_gap();
    start       <= 1'b1;
    op          <= code;
    pin_number  <= pin;
    trigger     <= trig;
    edge_rising <= rise;
    time_now    <= now;
    do @(posedge clk); while (busy);
  endtask

  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (pending != 0 || busy);
    repeat (LATENCY) @(posedge clk);
  endtask

  task automatic set_window(input logic [31:0] value);
    window_now = int'(value[15:0]);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_WINDOW;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic random_request();
    int          roll;
    op_t         code;
    logic [5:0]  pin;
    pin[5]   = 1'b0;
    pin[4]   = 1'($urandom_range(1));
    pin[3:0] = line_pool[$urandom_range(3)];
    if ($urandom_range(99) < 6) pin = 6'($urandom_range(63));
    roll = $urandom_range(99);
    if (roll < 22) code = OP_REG;
    else if (roll < 36) code = OP_UNREG;
    else if (roll < 96) code = OP_EDGE;
    else code = OP_NONE;
    case ($urandom_range(9))
      0: clock_ms = $urandom();
      1: clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 2 * window_now);
      default: clock_ms = clock_ms + $urandom_range(0, 2 * window_now + 4);
    endcase
    issue(code, pin, 2'($urandom_range(3)), 1'($urandom_range(1)), clock_ms);
  endtask

  initial begin
    int k;
    int ph;
    int n;
    rst         = 1'b1;
    start       = 1'b0;
    op          = OP_NONE;
    pin_number  = 6'd0;
    trigger     = 2'd0;
    edge_rising = 1'b0;
    time_now    = 32'd0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = ADDR_WINDOW;
    pwdata      = 32'd0;
    steady      = 1'b0;
    window_now  = int'(WINDOW_RESET);
    clock_ms    = 32'd0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // edge on a disabled line, unused op, out-of-range pins, unregister with no slot
    issue(OP_EDGE, 6'd0, TRIG_RISE, 1'b1, 32'd0);
    issue(OP_NONE, 6'd63, 2'd3, 1'b1, 32'hFFFF_FFFF);
    issue(OP_REG, 6'd32, 2'd0, 1'b0, 32'd0);
    issue(OP_UNREG, 6'd63, 2'd0, 1'b0, 32'd0);
    issue(OP_UNREG, 6'd5, 2'd0, 1'b0, 32'd0);
    // port B rising-only line, wrap across zero, window boundary
    issue(OP_REG, 6'd19, TRIG_RISE, 1'b0, 32'd0);
    issue(OP_EDGE, 6'd19, 2'd0, 1'b1, 32'hFFFF_FFFF);
    issue(OP_EDGE, 6'd3, 2'd0, 1'b1, 32'hFFFF_FFFF);
    issue(OP_EDGE, 6'd19, 2'd0, 1'b0, 32'h0000_1000);
    issue(OP_EDGE, 6'd19, 2'd0, 1'b1, 32'h0000_0044);
    issue(OP_EDGE, 6'd19, 2'd0, 1'b1, 32'h0000_0045);
    // fill the table on one line, overflow it, then fire every slot at once
    for (k = 0; k < 15; k++) issue(OP_REG, 6'd3, (k % 2) ? 2'd3 : 2'd0, 1'b0, 32'd0);
    issue(OP_REG, 6'd7, TRIG_FALL, 1'b1, 32'd0);
    issue(OP_EDGE, 6'd3, 2'd0, 1'b0, 32'h8000_0000);
    issue(OP_EDGE, 6'd7, 2'd0, 1'b0, 32'h8000_0000);
    // free the table
    for (k = 0; k < 15; k++) issue(OP_UNREG, 6'd3, 2'd0, 1'b0, 32'd0);
    issue(OP_UNREG, 6'd19, 2'd0, 1'b0, 32'd0);
    issue(OP_UNREG, 6'd7, 2'd0, 1'b0, 32'd0);

    for (ph = 0; ph < PHASES; ph++) begin
      drain();
      case (ph)
        0: set_window(32'hA5A5_0000);
        1: set_window(32'h5A5A_FFFF);
        2: set_window(32'd1);
        3: set_window($urandom_range(2, 300));
        default: set_window({16'd0, WINDOW_RESET});
      endcase
      for (k = 0; k < 4; k++) line_pool[k] = 4'($urandom_range(15));
      steady = (ph == 1);
      for (n = 0; n < PHASE_ITEMS; n++) begin
        // hold off until every outstanding result is in
        if (ph == 2 && n == PHASE_ITEMS / 2) drain();
        random_request();
      end
    end
    drain();

    $display("Ran %0d requests with %0d debounced reports across %0d window settings",
             requests_seen, reports_seen, PHASES + 1);
    if (fail_count == 0) begin
      $display("debounced_pin_edge_event_table_top verification clean");
    end else begin
      $display("debounced_pin_edge_event_table_top verification failed");
    end
    $finish;
  end

endmodule
